### hw/rtl/bmd_pkg.sv
package bmd_pkg;

   // fixed field widths
   localparam int CMD_W    = 3;
   localparam int HANDLE_W = 8;
   localparam int STATUS_W = 3;
   localparam int CFG_W    = 7;

   // command codes
   localparam logic [CMD_W-1:0] CMD_POST_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POST_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ACCEPT     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RELEASE    = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_BUSY    = 3'd4;

   // controller states
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   // per-cycle operation broadcast along the cell row
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_POP_FRONT,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [HANDLE_W-1:0]  handle;
   } cell_ctl_type;

endpackage

### hw/rtl/bmd_if.sv
// command channel
interface bmd_req_if;
   import bmd_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [HANDLE_W-1:0] handle;
   modport source (output valid, command, handle, input ready);
   modport sink   (input valid, command, handle, output ready);
endinterface

// result channel
interface bmd_rsp_if;
   import bmd_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] out_handle;
   logic [CFG_W-1:0]    held_count;
   logic [CFG_W-1:0]    free_slots;
   modport source (output valid, status, out_handle, held_count, free_slots, input ready);
   modport sink   (input valid, status, out_handle, held_count, free_slots, output ready);
endinterface

// capacity register write channel
interface bmd_csr_if;
   import bmd_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] capacity;
   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

### hw/rtl/bmd_cell.sv
module bmd_cell #(
   parameter int INDEX = 0,
   parameter int POS_W = 6
) (
   input  logic                            clock,
   input  bmd_pkg::cell_ctl_type           ctl,
   input  logic [POS_W-1:0]                load_pos,
   input  logic [bmd_pkg::HANDLE_W-1:0]    from_front,
   input  logic [bmd_pkg::HANDLE_W-1:0]    from_back,
   output logic [bmd_pkg::HANDLE_W-1:0]    handle_out
);
   import bmd_pkg::*;

   logic [HANDLE_W-1:0] handle_ff;
   logic [HANDLE_W-1:0] handle_in;

   // next handle: keep, take a neighbor's, or load a posted handle at the tail
   always_comb begin
      handle_in = handle_ff;
      case (ctl.op)
         CELL_HOLD:       handle_in = handle_ff;
         CELL_PUSH_FRONT: handle_in = from_front;
         CELL_POP_FRONT:  handle_in = from_back;
         CELL_LOAD: begin
            if (load_pos == POS_W'(INDEX)) begin
               handle_in = ctl.handle;
            end
         end
         default:         handle_in = handle_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
   end

   assign handle_out = handle_ff;

endmodule

### hw/rtl/bounded_message_deque.sv
// Bounded deque of message handles. Handles sit in a row of QUEUE_DEPTH cells with the
// front in cell 0: a post to the front shifts the row back by one, an accept shifts it
// forward, and a post to the back loads the cell at the current count. An on-queue mark
// per handle lives in a HANDLE_COUNT x 1 memory with a registered read port. After reset
// the mark memory is cleared one entry a cycle, during which no command is taken
// (capacity writes are). Each command is then accepted in S_IDLE, where its mark is
// read, and executed in S_EXEC, which updates the row, the mark and the count and loads
// the result register, waiting while that register holds a result not yet taken. The
// next command is accepted while a result still waits in the output register.
module bounded_message_deque #(
   parameter int QUEUE_DEPTH  = 64,
   parameter int HANDLE_COUNT = 256
) (
   input  logic         clock,
   input  logic         reset,
   bmd_req_if.sink      req_if,
   bmd_rsp_if.source    rsp_if,
   bmd_csr_if.sink      csr_if
);
   import bmd_pkg::*;

   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W  = $clog2(QUEUE_DEPTH);
   localparam int MARK_W = $clog2(HANDLE_COUNT);
   localparam int CAP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int HWIDE  = (MARK_W > HANDLE_W) ? MARK_W : HANDLE_W;

   state_type state_ff, state_in;

   logic [MARK_W-1:0]   clr_idx_ff, clr_idx_in;
   logic [CFG_W-1:0]    cap_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [HANDLE_W-1:0] hdl_ff;
   logic                mark_rd_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [HANDLE_W-1:0] taken_ff, taken_in;
   logic [CFG_W-1:0]    held_ff, held_in;
   logic [CFG_W-1:0]    free_ff, free_in;

   logic                mark_mem [HANDLE_COUNT];

   logic                req_fire;
   logic                exec_go;
   logic                clear_done;
   logic                mark_we;
   logic [MARK_W-1:0]   mark_waddr;
   logic                mark_wdata;
   logic [MARK_W-1:0]   req_addr;
   logic [MARK_W-1:0]   front_addr;
   logic [HWIDE-1:0]    req_wide;
   logic [HWIDE-1:0]    front_wide;

   logic [CNT_W-1:0]    cap_eff;
   logic [CAP_W-1:0]    cap_wide;
   logic                hdl_ok;
   logic                front_ok;

   logic                ex_mark_we;
   logic [MARK_W-1:0]   ex_mark_addr;
   logic                ex_mark_data;
   cell_ctl_type        cell_ctl;
   logic [HANDLE_W-1:0] cell_q [QUEUE_DEPTH];

   // capacity register, always ready
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CFG_W'(QUEUE_DEPTH);
      end else if (csr_if.valid) begin
         cap_ff <= csr_if.capacity;
      end
   end

   // capacity limited to the row depth
   always_comb begin
      cap_wide = CAP_W'(cap_ff);
      if (cap_wide > CAP_W'(QUEUE_DEPTH)) begin
         cap_eff = CNT_W'(QUEUE_DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   // handle to mark address
   assign req_wide   = HWIDE'(req_if.handle);
   assign req_addr   = req_wide[MARK_W-1:0];
   assign front_wide = HWIDE'(cell_q[0]);
   assign front_addr = front_wide[MARK_W-1:0];

   assign req_fire   = req_if.valid && req_if.ready;
   assign exec_go    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_if.ready);
   assign clear_done = (clr_idx_ff == MARK_W'(HANDLE_COUNT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // state outputs: ready, clearing sweep and mark write port
   always_comb begin
      req_if.ready = 1'b0;
      clr_idx_in   = clr_idx_ff;
      mark_we      = 1'b0;
      mark_waddr   = clr_idx_ff;
      mark_wdata   = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mark_we    = 1'b1;
            clr_idx_in = clr_idx_ff + MARK_W'(1);
         end
         S_IDLE: begin
            req_if.ready = 1'b1;
         end
         S_EXEC: begin
            mark_we    = exec_go && ex_mark_we;
            mark_waddr = ex_mark_addr;
            mark_wdata = ex_mark_data;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   // mark memory, registered read of the accepted handle
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      if (req_fire) begin
         mark_rd_ff <= mark_mem[req_addr];
      end
   end

   // capture accepted transaction
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_if.command;
         hdl_ff <= req_if.handle;
      end
   end

   assign hdl_ok   = (hdl_ff != '0) && (32'(hdl_ff) < 32'(HANDLE_COUNT));
   assign front_ok = 32'(cell_q[0]) < 32'(HANDLE_COUNT);

   // command execution
   always_comb begin
      status_in     = STAT_INVALID;
      taken_in      = '0;
      count_in      = count_ff;
      ex_mark_we    = 1'b0;
      ex_mark_data  = 1'b0;
      cell_ctl.op     = CELL_HOLD;
      cell_ctl.handle = hdl_ff;
      ex_mark_addr  = MARK_W'(HWIDE'(hdl_ff));
      case (cmd_ff)
         CMD_POST_BACK, CMD_POST_FRONT: begin
            if (!hdl_ok) begin
               status_in = STAT_INVALID;
            end else if (count_ff >= cap_eff) begin
               status_in = STAT_FULL;
            end else if (mark_rd_ff) begin
               status_in = STAT_INVALID;
            end else begin
               status_in    = STAT_OK;
               ex_mark_we   = 1'b1;
               ex_mark_data = 1'b1;
               count_in     = count_ff + CNT_W'(1);
               cell_ctl.op  = (cmd_ff == CMD_POST_BACK) ? CELL_LOAD : CELL_PUSH_FRONT;
            end
         end
         CMD_ACCEPT, CMD_PEEK: begin
            if (count_ff == '0) begin
               status_in = STAT_EMPTY;
            end else begin
               status_in = STAT_OK;
               taken_in  = cell_q[0];
               if (cmd_ff == CMD_ACCEPT) begin
                  ex_mark_we   = front_ok;
                  ex_mark_addr = front_addr;
                  ex_mark_data = 1'b0;
                  count_in     = count_ff - CNT_W'(1);
                  cell_ctl.op  = CELL_POP_FRONT;
               end
            end
         end
         CMD_RELEASE: begin
            if (!hdl_ok) begin
               status_in = STAT_INVALID;
            end else if (mark_rd_ff) begin
               status_in = STAT_BUSY;
            end else begin
               status_in = STAT_OK;
            end
         end
         default: status_in = STAT_INVALID;
      endcase
      if (!exec_go) begin
         cell_ctl.op = CELL_HOLD;
      end
   end

   // result fields from the count after this command
   always_comb begin
      held_in = CFG_W'(count_in);
      if (cap_eff > count_in) begin
         free_in = CFG_W'(cap_eff - count_in);
      end else begin
         free_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (exec_go) begin
         count_ff <= count_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         status_ff <= status_in;
         taken_ff  <= taken_in;
         held_ff   <= held_in;
         free_ff   <= free_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.out_handle = taken_ff;
   assign rsp_if.held_count = held_ff;
   assign rsp_if.free_slots = free_ff;

   // row of handle cells, front at cell 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [HANDLE_W-1:0] front_nb;
      logic [HANDLE_W-1:0] back_nb;
      if (i == 0) begin : g_head
         assign front_nb = hdl_ff;
      end else begin : g_mid
         assign front_nb = cell_q[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign back_nb = '0;
      end else begin : g_body
         assign back_nb = cell_q[i+1];
      end
      bmd_cell #(
         .INDEX (i),
         .POS_W (POS_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .load_pos   (count_ff[POS_W-1:0]),
         .from_front (front_nb),
         .from_back  (back_nb),
         .handle_out (cell_q[i])
      );
   end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import bmd_pkg::*;

   localparam int RING_DEPTH = 64;
   localparam int MARK_COUNT = 256;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int RECENT_KEEP = 16;

   localparam logic [HANDLE_W-1:0] NULL_HANDLE = 8'd0;
   localparam logic [CFG_W-1:0]    FULL_CAP = CFG_W'(RING_DEPTH);
   // command codes with no defined operation
   localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_C = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]    command;
      logic [HANDLE_W-1:0] handle;
      int unsigned         gap;
   } cmd_txn_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] out_handle;
      logic [CFG_W-1:0]    held_count;
      logic [CFG_W-1:0]    free_slots;
   } outcome_type;

   logic clock;
   logic reset = 1'b1;

   bmd_req_if req_bus ();
   bmd_rsp_if rsp_bus ();
   bmd_csr_if csr_bus ();

   bounded_message_deque #(
      .QUEUE_DEPTH  (RING_DEPTH),
      .HANDLE_COUNT (MARK_COUNT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // stimulus and expectation stores
   cmd_txn_type pending_cmds[$];
   outcome_type expected_outcomes[$];
   logic [HANDLE_W-1:0] recent_posts[$];

   // shadow copy of the deque state
   logic [HANDLE_W-1:0] held_handles[$];
   bit                  on_queue[MARK_COUNT];
   logic [CFG_W-1:0]    capacity_reg;

   int unsigned fail_count = 0;
   int unsigned gap_count = 0;
   int unsigned stall_left = 0;
   bit tx_quiet = 1'b0;
   bit rx_quiet = 1'b0;
   bit hold_go = 1'b0;
   logic hold_off = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // expected result of one command, applied to the shadow state
   function automatic void predict_outcome(input logic [CMD_W-1:0] cmd,
                                           input logic [HANDLE_W-1:0] h);
      outcome_type r;
      int unsigned lim;
      lim = (capacity_reg > RING_DEPTH) ? RING_DEPTH : capacity_reg;
      r.status = STAT_INVALID;
      r.out_handle = NULL_HANDLE;
      case (cmd)
         CMD_POST_BACK, CMD_POST_FRONT: begin
            if (h == NULL_HANDLE)
               r.status = STAT_INVALID;
            else if (held_handles.size() >= lim)
               r.status = STAT_FULL;
            else if (on_queue[h])
               r.status = STAT_INVALID;
            else begin
               on_queue[h] = 1'b1;
               if (cmd == CMD_POST_BACK)
                  held_handles.push_back(h);
               else
                  held_handles.push_front(h);
               r.status = STAT_OK;
            end
         end
         CMD_ACCEPT, CMD_PEEK: begin
            if (held_handles.size() == 0)
               r.status = STAT_EMPTY;
            else begin
               r.out_handle = held_handles[0];
               if (cmd == CMD_ACCEPT) begin
                  on_queue[held_handles[0]] = 1'b0;
                  void'(held_handles.pop_front());
               end
               r.status = STAT_OK;
            end
         end
         CMD_RELEASE: begin
            if (h == NULL_HANDLE)
               r.status = STAT_INVALID;
            else if (on_queue[h])
               r.status = STAT_BUSY;
            else
               r.status = STAT_OK;
         end
         default: r.status = STAT_INVALID;
      endcase
      r.held_count = CFG_W'(held_handles.size());
      r.free_slots = CFG_W'((lim > held_handles.size()) ? lim - held_handles.size() : 0);
      expected_outcomes.push_back(r);
   endfunction

   function automatic void compare_field(input string label, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         fail_count++;
      end
   endfunction

   // compare one result transaction with the oldest expectation
   function automatic void check_outcome();
      outcome_type want;
      if (expected_outcomes.size() == 0) begin
         $display("%0t: result with nothing outstanding, expected none, actual status %0d",
                  $time, rsp_bus.status);
         fail_count++;
      end else begin
         want = expected_outcomes.pop_front();
         compare_field("status", 8'(want.status), 8'(rsp_bus.status));
         compare_field("out_handle", want.out_handle, rsp_bus.out_handle);
         compare_field("held_count", 8'(want.held_count), 8'(rsp_bus.held_count));
         compare_field("free_slots", 8'(want.free_slots), 8'(rsp_bus.free_slots));
      end
   endfunction

   // command driver: one pending transaction at a time, with its gap first
   always @(posedge clock) begin : cmd_driver
      logic        offer;
      cmd_txn_type next_cmd;
      offer = req_bus.valid;
      if (reset) begin
         offer = 1'b0;
         gap_count = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_outcome(req_bus.command, req_bus.handle);
            offer = 1'b0;
         end
         if (!offer && pending_cmds.size() != 0) begin
            if (gap_count < pending_cmds[0].gap)
               gap_count++;
            else begin
               next_cmd = pending_cmds.pop_front();
               req_bus.command <= next_cmd.command;
               req_bus.handle <= next_cmd.handle;
               gap_count = 0;
               offer = 1'b1;
            end
         end
      end
      req_bus.valid <= offer;
   end

   // result monitor with random stalls
   always @(posedge clock) begin : rsp_monitor
      if (reset)
         stall_left = 0;
      else if (rsp_bus.valid && rsp_bus.ready) begin
         check_outcome();
         stall_left = rx_quiet ? 0 : $urandom_range(0, 15);
      end else if (stall_left != 0)
         stall_left--;
      rsp_bus.ready <= !reset && stall_left == 0 && !hold_off;
   end

   // long receiver hold-off so the block backs up into its input
   initial begin : rsp_hold
      wait (hold_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] h);
      cmd_txn_type t;
      t.command = cmd;
      t.handle = h;
      t.gap = tx_quiet ? 0 : $urandom_range(0, 15);
      pending_cmds.push_back(t);
      if ((cmd == CMD_POST_BACK || cmd == CMD_POST_FRONT) && h != NULL_HANDLE) begin
         recent_posts.push_back(h);
         if (recent_posts.size() > RECENT_KEEP)
            void'(recent_posts.pop_front());
      end
   endtask

   // wait until every transaction has been sent and answered
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_bus.valid || expected_outcomes.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.capacity <= value;
      do @(posedge clock);
      while (!csr_bus.ready);
      capacity_reg = value;
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // handle for a post or release: mostly fresh, often recently posted, rarely null
   function automatic logic [HANDLE_W-1:0] pick_handle();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         return NULL_HANDLE;
      else if (roll < 40 && recent_posts.size() != 0)
         return recent_posts[$urandom_range(0, recent_posts.size() - 1)];
      else
         return HANDLE_W'($urandom_range(1, 255));
   endfunction

   task automatic random_phase(input logic [CFG_W-1:0] cap, input int unsigned count,
                               input int unsigned post_pct, input bit squeeze);
      int unsigned roll;
      int unsigned pick;
      wait_drained();
      write_capacity(cap);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      repeat (count) begin
         roll = $urandom_range(0, 99);
         pick = $urandom_range(0, 99);
         if (roll < post_pct)
            queue_cmd($urandom_range(0, 1) ? CMD_POST_FRONT : CMD_POST_BACK, pick_handle());
         else if (pick < 50)
            queue_cmd(CMD_ACCEPT, HANDLE_W'($urandom_range(0, 255)));
         else if (pick < 70)
            queue_cmd(CMD_PEEK, HANDLE_W'($urandom_range(0, 255)));
         else if (pick < 93)
            queue_cmd(CMD_RELEASE, pick_handle());
         else
            queue_cmd(CMD_W'($urandom_range(CMD_UNUSED_A, CMD_UNUSED_C)),
                      HANDLE_W'($urandom_range(0, 255)));
      end
      if (squeeze)
         hold_go = 1'b1;
   endtask

   // reset, directed cases, then random phases over several capacities
   initial begin : stimulus
      req_bus.valid = 1'b0;
      req_bus.command = CMD_PEEK;
      req_bus.handle = NULL_HANDLE;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.capacity = '0;
      capacity_reg = FULL_CAP;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty queue, null handle, duplicates, busy release, unknown commands
      write_capacity(FULL_CAP);
      queue_cmd(CMD_PEEK, NULL_HANDLE);
      queue_cmd(CMD_ACCEPT, NULL_HANDLE);
      queue_cmd(CMD_POST_BACK, NULL_HANDLE);
      queue_cmd(CMD_RELEASE, NULL_HANDLE);
      queue_cmd(CMD_POST_BACK, 8'd1);
      queue_cmd(CMD_POST_FRONT, 8'd255);
      queue_cmd(CMD_POST_BACK, 8'h55);
      queue_cmd(CMD_POST_BACK, 8'd1);
      queue_cmd(CMD_RELEASE, 8'd255);
      queue_cmd(CMD_RELEASE, 8'hAA);
      queue_cmd(CMD_UNUSED_A, 8'hAA);
      queue_cmd(CMD_UNUSED_B, 8'd255);
      queue_cmd(CMD_UNUSED_C, 8'd1);
      queue_cmd(CMD_PEEK, NULL_HANDLE);
      queue_cmd(CMD_ACCEPT, NULL_HANDLE);
      queue_cmd(CMD_ACCEPT, NULL_HANDLE);
      queue_cmd(CMD_ACCEPT, NULL_HANDLE);

      // zero capacity: every post is full
      wait_drained();
      write_capacity(7'd0);
      queue_cmd(CMD_POST_BACK, 8'd5);
      queue_cmd(CMD_POST_FRONT, 8'd6);
      queue_cmd(CMD_RELEASE, 8'd5);

      // capacity of one
      wait_drained();
      write_capacity(7'd1);
      queue_cmd(CMD_POST_BACK, 8'd7);
      queue_cmd(CMD_POST_FRONT, 8'd8);
      queue_cmd(CMD_PEEK, NULL_HANDLE);
      queue_cmd(CMD_ACCEPT, NULL_HANDLE);

      // fill past the ring depth under an oversized capacity, with a long hold-off
      random_phase(7'd127, 110, 90, 1'b1);
      random_phase(7'd127, 60, 10, 1'b0);
      random_phase(7'd3, 40, 50, 1'b0);
      random_phase(7'd100, 40, 55, 1'b0);
      random_phase(7'd2, 40, 50, 1'b0);
      random_phase(FULL_CAP, 50, 60, 1'b0);
      random_phase(7'd17, 40, 55, 1'b0);
      random_phase(7'd0, 20, 50, 1'b0);
      random_phase(FULL_CAP, 50, 30, 1'b0);

      wait_drained();
      if (fail_count == 0 && expected_outcomes.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // run limit
   initial begin : watchdog
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
